// ===== rtl/core/double_ended_queue_unit_assert.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit_assert.svh: assertion macros
// Shared concurrent assertion shorthand, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// Plain clocked property, disabled while rst_ni is low.
`define DEQU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Property that only matters when a result is presented.
`define DEQU_ASSERT_OUT(lbl, prop, msg) \
  `DEQU_ASSERT(lbl, out_valid_o |-> (prop), msg)

`endif

// ===== rtl/core/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: double-ended queue shared types
// Request kinds, result status codes and the underflow pop value.
// ----------------------------------------------------------------------------
package deq_pkg;

  typedef enum logic [2:0] {
    KIND_PUSH_REAR  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_REAR   = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  localparam logic signed [31:0] PopUnderflowValue = -32'sd1;

endpackage

// ===== rtl/core/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit: bounded deque on a ring buffer
// Push/pop at either end of a DEPTH-entry ring; one result per request.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake               Payload
// in       in   in_valid_i/in_ready_o   kind_i, push_value_i
// out      out  out_valid_o/out_ready_i pop_value_o, status_o, entry_count_o,
//                                       is_empty_o, front_value_o, rear_value_o
//
// Push, query and pops that leave fewer than two entries: result registered on accept.
// Pops that leave two or more entries pass through the FILL state, where the exposed
// end is refilled by one registered read of the ring memory; no item is taken there.
// Both end values live in registers, so each item needs at most one access.
// Reset clears state, output valid, pointers and count only; the ring memory is not cleared.
// A result waits in the output register; the next item is taken in the same
// cycle that result is taken.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      kind_i,
  input  logic signed [31:0]              push_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [31:0]              pop_value_o,
  output logic [1:0]                      status_o,
  output logic [$clog2(DEPTH+1)-1:0]      entry_count_o,
  output logic                            is_empty_o,
  output logic signed [31:0]              front_value_o,
  output logic signed [31:0]              rear_value_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FILL = 1'b1;

  typedef logic [IdxW-1:0]       idx_t;
  typedef logic [CntW-1:0]       cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  function automatic idx_t idx_inc(input idx_t i);
    return (i == IdxW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic idx_t idx_dec(input idx_t i);
    return (i == '0) ? IdxW'(DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic logic signed [31:0] to_out(input data_t d);
    return 32'($signed(d));
  endfunction

  // ring memory
  data_t mem [DEPTH];
  data_t rd_data_q;
  logic  mem_we, mem_re;
  idx_t  wr_addr, rd_addr;
  data_t wr_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // control and end registers
  logic  state_q, state_d;
  idx_t  front_idx_q, front_idx_d;
  idx_t  rear_idx_q, rear_idx_d;
  cnt_t  count_q, count_d;
  data_t front_q, front_d;
  data_t rear_q, rear_d;
  logic  fill_front_q;
  logic  out_valid_q, out_valid_d;

  logic signed [31:0] pop_value_q, front_value_q, rear_value_q;
  status_e            status_q;
  cnt_t               entry_count_q;
  logic               is_empty_q;

  logic    accept, is_push, is_pop, full, empty, do_push, do_pop, need_fill;
  logic    pop_front;
  data_t   push_data;
  status_e status_n;
  logic signed [31:0] pop_n;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign is_push   = (kind_i == KIND_PUSH_REAR) || (kind_i == KIND_PUSH_FRONT);
  assign is_pop    = (kind_i == KIND_POP_REAR) || (kind_i == KIND_POP_FRONT);
  assign pop_front = (kind_i == KIND_POP_FRONT);
  assign full      = (count_q == CntW'(DEPTH));
  assign empty     = (count_q == '0);
  assign do_push   = is_push && !full;
  assign do_pop    = is_pop && !empty;
  assign push_data = DATA_WIDTH'(push_value_i);

  always_comb begin
    front_idx_d = front_idx_q;
    rear_idx_d  = rear_idx_q;
    count_d     = count_q;
    front_d     = front_q;
    rear_d      = rear_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    wr_addr     = rear_idx_q;
    rd_addr     = idx_inc(front_idx_q);
    wr_data     = push_data;
    need_fill   = 1'b0;
    status_n    = STATUS_OK;
    pop_n       = '0;

    if (is_push && full) begin
      status_n = STATUS_OVERFLOW;
    end else if (is_pop && empty) begin
      status_n = STATUS_UNDERFLOW;
      pop_n    = PopUnderflowValue;
    end

    if (do_push) begin
      count_d = count_q + 1'b1;
      mem_we  = accept;
      if (kind_i == KIND_PUSH_REAR) begin
        wr_addr    = rear_idx_q;
        rear_idx_d = idx_inc(rear_idx_q);
        rear_d     = push_data;
        if (empty) begin
          front_d = push_data;
        end
      end else begin
        front_idx_d = idx_dec(front_idx_q);
        wr_addr     = idx_dec(front_idx_q);
        front_d     = push_data;
        if (empty) begin
          rear_d = push_data;
        end
      end
    end else if (do_pop) begin
      count_d   = count_q - 1'b1;
      need_fill = (count_q > CntW'(2));
      mem_re    = accept && need_fill;
      if (pop_front) begin
        pop_n       = to_out(front_q);
        front_idx_d = idx_inc(front_idx_q);
        rd_addr     = idx_inc(front_idx_q);
        // single survivor is the rear entry
        front_d     = rear_q;
      end else begin
        pop_n      = to_out(rear_q);
        rear_idx_d = idx_dec(rear_idx_q);
        rd_addr    = idx_dec(idx_dec(rear_idx_q));
        rear_d     = front_q;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (state_q == ST_FILL) begin
      state_d     = ST_IDLE;
      out_valid_d = 1'b1;
    end else if (accept) begin
      state_d     = need_fill ? ST_FILL : ST_IDLE;
      out_valid_d = !need_fill;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_idx_q <= '0;
      rear_idx_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        front_idx_q <= front_idx_d;
        rear_idx_q  <= rear_idx_d;
        count_q     <= count_d;
      end
    end
  end

  // end values and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILL) begin
      if (fill_front_q) begin
        front_q       <= rd_data_q;
        front_value_q <= to_out(rd_data_q);
      end else begin
        rear_q       <= rd_data_q;
        rear_value_q <= to_out(rd_data_q);
      end
    end else if (accept) begin
      front_q       <= front_d;
      rear_q        <= rear_d;
      fill_front_q  <= pop_front;
      pop_value_q   <= pop_n;
      status_q      <= status_n;
      entry_count_q <= count_d;
      is_empty_q    <= (count_d == '0);
      front_value_q <= (count_d == '0) ? '0 : to_out(front_d);
      rear_value_q  <= (count_d == '0) ? '0 : to_out(rear_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pop_value_o   = pop_value_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;
  assign is_empty_o    = is_empty_q;
  assign front_value_o = front_value_q;
  assign rear_value_o  = rear_value_q;

endmodule

// ===== rtl/core/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker: port-level checks for double_ended_queue_unit
// Watches the result channel: items held while stalled, fields consistent.
// ----------------------------------------------------------------------------
`include "double_ended_queue_unit_assert.svh"

module deq_checker
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [31:0]         pop_value_o,
  input logic [1:0]                 status_o,
  input logic [$clog2(DEPTH+1)-1:0] entry_count_o,
  input logic                       is_empty_o,
  input logic signed [31:0]         front_value_o,
  input logic signed [31:0]         rear_value_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  `DEQU_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(pop_value_o) && $stable(status_o) && $stable(entry_count_o), "result item changed while stalled")
  `DEQU_ASSERT_OUT(a_empty_flag, is_empty_o == (entry_count_o == '0), "empty flag disagrees with count")
  `DEQU_ASSERT_OUT(a_empty_ends, !is_empty_o || (front_value_o == '0 && rear_value_o == '0), "end values not zero when empty")
  `DEQU_ASSERT_OUT(a_underflow, status_o != STATUS_UNDERFLOW || (is_empty_o && pop_value_o == PopUnderflowValue), "bad underflow item")
  `DEQU_ASSERT_OUT(a_overflow, status_o != STATUS_OVERFLOW || entry_count_o == CntW'(DEPTH), "overflow without full ring")

endmodule

bind double_ended_queue_unit deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
